// ===== hw/rtl/fdf_pkg.sv =====
// Shared types, constants and the fixed low-pass kernel of the decimating FIR filter.
// Used by the channel interfaces, the serial MAC and the top level. No dependencies.

package fdf_pkg;

  // Field widths of the input and result items.
  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 16;

  // Serial arithmetic: sample digits, one per cycle, most significant first.
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  // One full product, and the accumulator with room for the rounding offset.
  localparam int PROD_W = SAMPLE_W + COEFF_W;
  localparam int ACC_W  = 36;

  // Defaults of the top-level parameters.
  localparam int TAP_COUNT_DEF           = 49;
  localparam int DECIMATION_DEF          = 4;
  localparam int COEFF_FRACTION_BITS_DEF = 17;

  // Kernel table addressing. Taps past the table have a zero coefficient.
  localparam int KERNEL_LEN   = 49;
  localparam int KERNEL_IDX_W = $clog2(KERNEL_LEN);
  localparam int TAP_IDX_W    = 8;

  // Saturation limits of the 16-bit result, as magnitudes.
  localparam int SAT_POS_MAG = 32767;
  localparam int SAT_NEG_MAG = 32768;

  // Symmetric low-pass taps, each round(tap * 131072).
  localparam logic signed [COEFF_W-1:0] KERNEL [KERNEL_LEN] = '{
      16'sd113,    16'sd1318,   16'sd1332,   16'sd1489,   16'sd1141,   16'sd343,
      -16'sd682,   -16'sd1536,  -16'sd1803,  -16'sd1236,  16'sd71,     16'sd1656,
      16'sd2817,   16'sd2877,   16'sd1516,   -16'sd1004,  -16'sd3797,  -16'sd5589,
      -16'sd5138,  -16'sd1724,  16'sd4498,   16'sd12415,  16'sd20215,  16'sd25921,
      16'sd28012,
      16'sd25921,  16'sd20215,  16'sd12415,  16'sd4498,   -16'sd1724,  -16'sd5138,
      -16'sd5589,  -16'sd3797,  -16'sd1004,  16'sd1516,   16'sd2877,   16'sd2817,
      16'sd1656,   16'sd71,     -16'sd1236,  -16'sd1803,  -16'sd1536,  -16'sd682,
      16'sd343,    16'sd1141,   16'sd1489,   16'sd1332,   16'sd1318,   16'sd113
  };

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_FLUSH,
    ST_ROUND,
    ST_SAT
  } fdf_state_e;

  // Control of the serial multiply-accumulate unit.
  typedef struct packed {
    logic clear;        // zero the product and the accumulator
    logic step;         // process one sample digit
    logic first_digit;  // first digit of a tap: load the sample, retire the last product
    logic flush;        // retire the last product of the kernel
  } mac_ctrl_t;

  // Coefficient of one tap; zero beyond the tabulated kernel.
  function automatic logic signed [COEFF_W-1:0] tap_coeff(input logic [TAP_IDX_W-1:0] idx);
    logic signed [COEFF_W-1:0] c;
    c = '0;
    if (idx < TAP_IDX_W'(KERNEL_LEN)) begin
      c = KERNEL[idx[KERNEL_IDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fdf_if.sv =====
// Valid/ready channel interfaces for the input samples and the filtered results.
// Depends on fdf_pkg for the field widths.

interface fdf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdf_pkg::SAMPLE_W-1:0]  sample;
  logic                                 block_start;

  modport source (output valid, output sample, output block_start, input ready);
  modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface fdf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdf_pkg::SAMPLE_W-1:0]  filtered_sample;
  logic                                 clipped;

  modport source (output valid, output filtered_sample, output clipped, input ready);
  modport sink   (input valid, input filtered_sample, input clipped, output ready);
endinterface

// ===== hw/rtl/fdf_mac.sv =====
// Digit-serial multiply-accumulate unit: one sample digit times one coefficient per cycle.
// Depends on fdf_pkg for widths and the control struct.

module fdf_mac (
  input  logic                                clk_i,
  input  fdf_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fdf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [fdf_pkg::COEFF_W-1:0]  coeff_i,
  output logic signed [fdf_pkg::ACC_W-1:0]    acc_o
);

  localparam int PP_W = fdf_pkg::COEFF_W + fdf_pkg::DIGIT_W + 1;

  logic        [fdf_pkg::SAMPLE_W-1:0] shift_q, shift_d;
  logic        [fdf_pkg::SAMPLE_W-1:0] src;
  logic signed [fdf_pkg::DIGIT_W:0]    digit;
  logic signed [PP_W-1:0]              part_prod;
  logic signed [fdf_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic signed [fdf_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic signed [fdf_pkg::ACC_W-1:0]    prod_ext;

  // The first digit of a tap comes straight from the sample; later ones from the shifter.
  assign src     = ctrl_i.first_digit ? sample_i : shift_q;
  assign shift_d = src << fdf_pkg::DIGIT_W;

  // The top digit carries the sign; the lower digits are unsigned.
  always_comb begin
    if (ctrl_i.first_digit) begin
      digit = {src[fdf_pkg::SAMPLE_W-1],
               src[fdf_pkg::SAMPLE_W-1 -: fdf_pkg::DIGIT_W]};
    end else begin
      digit = {1'b0, src[fdf_pkg::SAMPLE_W-1 -: fdf_pkg::DIGIT_W]};
    end
  end

  assign part_prod = coeff_i * digit;

  // Horner step over the digits of one product.
  always_comb begin
    if (ctrl_i.clear) begin
      prod_d = '0;
    end else if (ctrl_i.step) begin
      prod_d = (ctrl_i.first_digit ? fdf_pkg::PROD_W'(0) : (prod_q <<< fdf_pkg::DIGIT_W))
             + {{(fdf_pkg::PROD_W-PP_W){part_prod[PP_W-1]}}, part_prod};
    end else if (ctrl_i.flush) begin
      prod_d = '0;
    end else begin
      prod_d = prod_q;
    end
  end

  // A finished product is added while the next one starts.
  assign prod_ext = {{(fdf_pkg::ACC_W-fdf_pkg::PROD_W){prod_q[fdf_pkg::PROD_W-1]}}, prod_q};

  always_comb begin
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if ((ctrl_i.step && ctrl_i.first_digit) || ctrl_i.flush) begin
      acc_d = acc_q + prod_ext;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/fir_decimate_by_four_core.sv =====
// Top level of the decimate-by-four low-pass FIR filter: staging, delay line, sequencer,
// rounding and the output register. Depends on fdf_pkg, fdf_if and fdf_mac.
//
//   Channel  Role    Payload                       Transfer
//   in_i     sink    sample, block_start           in_i.valid && in_i.ready
//   out_o    source  filtered_sample, clipped      out_o.valid && out_o.ready
//
// A sample that does not complete a group is only staged. A sample that completes a group
// starts the delay-line loading, then the multiply over all taps in the single 16x4-bit
// serial multiplier (four sample digits per tap), then the steps that retire, round and
// saturate; no new sample is taken until the sequencer is back in idle. Reset clears the
// delay line and the group count. A result waits in the output register while new samples
// are taken; only the final saturate step stalls when that register is still full.

module fir_decimate_by_four_core #(
  parameter int TAP_COUNT           = fdf_pkg::TAP_COUNT_DEF,
  parameter int DECIMATION          = fdf_pkg::DECIMATION_DEF,
  parameter int COEFF_FRACTION_BITS = fdf_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdf_in_if.sink      in_i,
  fdf_out_if.source   out_o
);

  localparam int TAP_W  = $clog2(TAP_COUNT);
  localparam int FILL_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [fdf_pkg::ACC_W-1:0] HALF =
      fdf_pkg::ACC_W'(1) << (COEFF_FRACTION_BITS - 1);

  fdf_pkg::fdf_state_e state_q, state_d;

  logic signed [fdf_pkg::SAMPLE_W-1:0] dl_q    [TAP_COUNT];
  logic signed [fdf_pkg::SAMPLE_W-1:0] stage_q [DECIMATION];
  logic signed [fdf_pkg::SAMPLE_W-1:0] dl_tail;
  logic signed [fdf_pkg::COEFF_W-1:0]  coeff_q;
  logic signed [fdf_pkg::ACC_W-1:0]    acc;

  logic [FILL_W-1:0]             fill_q, fill_eff, load_cnt_q;
  logic [TAP_W-1:0]              tap_q;
  logic [fdf_pkg::DIG_CNT_W-1:0] dig_q;
  logic                          in_xfer, group_done, last_load, last_digit, last_tap;
  logic                          slot_free;

  logic                          dl_shift, stage_shift, coeff_first, coeff_next;
  logic                          round_en, out_load;
  fdf_pkg::mac_ctrl_t            mac_ctrl;

  logic        [fdf_pkg::ACC_W-1:0]    mag_q, mag_d, quot;
  logic                                neg_q;
  logic signed [fdf_pkg::SAMPLE_W-1:0] sat_val;
  logic                                sat_clip;

  logic                                out_valid_q, clipped_q;
  logic signed [fdf_pkg::SAMPLE_W-1:0] filtered_q;

  // Group tracking: block_start drops whatever was staged.
  assign in_xfer    = in_i.valid && in_i.ready;
  assign fill_eff   = in_i.block_start ? '0 : fill_q;
  assign group_done = (fill_eff == FILL_W'(DECIMATION - 1));
  assign last_load  = (load_cnt_q == FILL_W'(DECIMATION - 1));
  assign last_digit = (dig_q == fdf_pkg::DIG_CNT_W'(fdf_pkg::NUM_DIGITS - 1));
  assign last_tap   = (tap_q == TAP_W'(TAP_COUNT - 1));
  assign slot_free  = !out_valid_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdf_pkg::ST_IDLE: begin
        if (in_xfer && group_done) state_d = fdf_pkg::ST_LOAD;
      end
      fdf_pkg::ST_LOAD: begin
        if (last_load) state_d = fdf_pkg::ST_MAC;
      end
      fdf_pkg::ST_MAC: begin
        if (last_digit && last_tap) state_d = fdf_pkg::ST_FLUSH;
      end
      fdf_pkg::ST_FLUSH: state_d = fdf_pkg::ST_ROUND;
      fdf_pkg::ST_ROUND: state_d = fdf_pkg::ST_SAT;
      fdf_pkg::ST_SAT: begin
        if (slot_free) state_d = fdf_pkg::ST_IDLE;
      end
      default: state_d = fdf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_i.ready  = 1'b0;
    dl_shift    = 1'b0;
    stage_shift = 1'b0;
    coeff_first = 1'b0;
    coeff_next  = 1'b0;
    round_en    = 1'b0;
    out_load    = 1'b0;
    mac_ctrl    = '0;
    unique case (state_q)
      fdf_pkg::ST_IDLE: in_i.ready = 1'b1;
      fdf_pkg::ST_LOAD: begin
        dl_shift       = 1'b1;
        stage_shift    = 1'b1;
        coeff_first    = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      fdf_pkg::ST_MAC: begin
        mac_ctrl.step        = 1'b1;
        mac_ctrl.first_digit = (dig_q == '0);
        dl_shift             = (dig_q == '0);
        coeff_next           = last_digit;
      end
      fdf_pkg::ST_FLUSH: mac_ctrl.flush = 1'b1;
      fdf_pkg::ST_ROUND: round_en = 1'b1;
      fdf_pkg::ST_SAT:   out_load = slot_free;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fdf_pkg::ST_IDLE;
      fill_q     <= '0;
      load_cnt_q <= '0;
      tap_q      <= '0;
      dig_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        fill_q <= group_done ? '0 : fill_eff + FILL_W'(1);
      end
      if (state_q == fdf_pkg::ST_LOAD) begin
        load_cnt_q <= last_load ? '0 : load_cnt_q + FILL_W'(1);
      end
      if (state_q == fdf_pkg::ST_MAC) begin
        dig_q <= dig_q + fdf_pkg::DIG_CNT_W'(1);
        if (last_digit) begin
          tap_q <= last_tap ? '0 : tap_q + TAP_W'(1);
        end
      end
    end
  end

  // Staging of a partial group, drained oldest first into the delay line.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_q[fill_eff] <= in_i.sample;
    end else if (stage_shift) begin
      for (int i = 0; i < DECIMATION - 1; i++) begin
        stage_q[i] <= stage_q[i + 1];
      end
    end
  end

  // Delay line: a push while loading, a full rotation over the taps while multiplying.
  assign dl_tail = (state_q == fdf_pkg::ST_LOAD) ? stage_q[0] : dl_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TAP_COUNT; j++) begin
        dl_q[j] <= '0;
      end
    end else if (dl_shift) begin
      for (int j = 0; j < TAP_COUNT - 1; j++) begin
        dl_q[j] <= dl_q[j + 1];
      end
      dl_q[TAP_COUNT - 1] <= dl_tail;
    end
  end

  // Coefficient of the tap being multiplied, fetched one tap ahead.
  always_ff @(posedge clk_i) begin
    if (coeff_first) begin
      coeff_q <= fdf_pkg::tap_coeff('0);
    end else if (coeff_next) begin
      coeff_q <= fdf_pkg::tap_coeff(fdf_pkg::TAP_IDX_W'(tap_q) + fdf_pkg::TAP_IDX_W'(1));
    end
  end

  fdf_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (dl_q[0]),
    .coeff_i  (coeff_q),
    .acc_o    (acc)
  );

  // Rounding half away from zero works on the magnitude.
  assign mag_d = acc[fdf_pkg::ACC_W-1] ? (HALF - $unsigned(acc)) : ($unsigned(acc) + HALF);

  always_ff @(posedge clk_i) begin
    if (round_en) begin
      mag_q <= mag_d;
      neg_q <= acc[fdf_pkg::ACC_W-1];
    end
  end

  // Scale down and saturate to 16 bits.
  assign quot = mag_q >> COEFF_FRACTION_BITS;

  always_comb begin
    if (!neg_q) begin
      sat_clip = (quot > fdf_pkg::ACC_W'(fdf_pkg::SAT_POS_MAG));
      sat_val  = sat_clip ? fdf_pkg::SAMPLE_W'(fdf_pkg::SAT_POS_MAG)
                          : quot[fdf_pkg::SAMPLE_W-1:0];
    end else begin
      sat_clip = (quot > fdf_pkg::ACC_W'(fdf_pkg::SAT_NEG_MAG));
      sat_val  = sat_clip ? fdf_pkg::SAMPLE_W'(fdf_pkg::SAT_NEG_MAG)
                          : fdf_pkg::SAMPLE_W'(fdf_pkg::SAMPLE_W'(0) - quot[fdf_pkg::SAMPLE_W-1:0]);
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= sat_val;
      clipped_q  <= sat_clip;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = filtered_q;
  assign out_o.clipped         = clipped_q;

  // A sample that completes a group always starts the delay-line load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_xfer && group_done) |=> (state_q == fdf_pkg::ST_LOAD))
    else $error("Completed group did not start the load.");

  // A pending result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == fdf_pkg::ST_SAT && out_valid_q && !out_o.ready) |=>
      (state_q == fdf_pkg::ST_SAT && out_valid_q))
    else $error("Result written over a pending output.");

  // The group count stays below the decimation factor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      fill_q <= FILL_W'(DECIMATION - 1))
    else $error("Group count out of range.");

  // Each multiply pass ends with the tap and digit counters back at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == fdf_pkg::ST_FLUSH) |-> (tap_q == '0 && dig_q == '0))
    else $error("Tap sequence ended out of step.");

endmodule
